@@ rtl/iee_pkg.sv @@
// Shared types, constants and microcode for the infix expression evaluator.
// Used by the channel interfaces, the arithmetic unit and the top level.
// No dependencies.
package iee_pkg;

  // Number format
  localparam int FRAC_BITS   = 16;
  localparam int VALUE_WIDTH = 48;
  localparam int CHAR_W      = 8;
  localparam int ACC_WIDTH   = 32;

  localparam logic [ACC_WIDTH-1:0] ACC_MAX = {ACC_WIDTH{1'b1}};

  // Number push: accumulator shifted into the fraction format
  localparam int PUSH_W = ACC_WIDTH + FRAC_BITS;
  localparam int CMP_W  = (PUSH_W > VALUE_WIDTH) ? PUSH_W : VALUE_WIDTH;

  // Multiplier: one chunk of the second operand per cycle
  localparam int MUL_CHUNK = 16;
  localparam int MUL_STEPS = (VALUE_WIDTH + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int MUL_PAD   = MUL_STEPS * MUL_CHUNK;
  localparam int PROD_W    = VALUE_WIDTH + MUL_PAD;

  // Divider: one quotient bit per cycle
  localparam int DIV_N  = VALUE_WIDTH + FRAC_BITS;
  localparam int CNT_W  = $clog2(DIV_N + 1);
  localparam int WIDE_W = PROD_W;

  typedef logic signed [VALUE_WIDTH-1:0] value_t;

  localparam value_t VALUE_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam value_t VALUE_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  localparam logic [WIDE_W-1:0] LIM_POS = WIDE_W'({1'b0, {(VALUE_WIDTH-1){1'b1}}});
  localparam logic [WIDE_W-1:0] LIM_NEG = LIM_POS + WIDE_W'(1);

  // Characters
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } op_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_MALFORMED,
    ST_DIV_ZERO,
    ST_OVERFLOW
  } status_t;

  typedef enum logic [1:0] {
    AS_IDLE,
    AS_MUL,
    AS_DIV,
    AS_FIN
  } alu_state_t;

  typedef struct packed {
    logic   start;
    op_t    op;
    value_t a;
    value_t b;
  } alu_req_t;

  typedef struct packed {
    logic   busy;
    value_t value;
    logic   ovf;
    logic   dz;
  } alu_rsp_t;

  // Overflow only replaces ok; malformed / divide by zero replace ok or overflow
  function automatic status_t raise_status(status_t cur, status_t s);
    status_t r;
    r = cur;
    if (s == ST_OVERFLOW) begin
      if (cur == ST_OK) r = ST_OVERFLOW;
    end else if (cur == ST_OK || cur == ST_OVERFLOW) begin
      r = s;
    end
    return r;
  endfunction

  function automatic logic [1:0] prio(op_t op);
    return (op == OP_MUL || op == OP_DIV) ? 2'd2 : 2'd1;
  endfunction

  // Microcode
  localparam int UPC_W = 5;

  typedef enum logic [3:0] {
    U_NOP,
    U_FETCH,
    U_DIGIT,
    U_BAD_OTHER,
    U_MARK_BAD,
    U_PUSH_NUM,
    U_ALU_START,
    U_RED_WRITE,
    U_PUSH_OP,
    U_FIN_PUSH,
    U_EMIT
  } uop_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_BEAT,
    C_DIGIT,
    C_OPER,
    C_IN_NUMBER,
    C_NO_REDUCE,
    C_ALU_BUSY,
    C_NOT_LAST,
    C_OUT_BLOCKED
  } cond_t;

  typedef struct packed {
    uop_t             uop;
    cond_t            cond;
    logic [UPC_W-1:0] target;
  } ucode_t;

  localparam logic [UPC_W-1:0] L_FETCH    = UPC_W'(0);
  localparam logic [UPC_W-1:0] L_DIGIT    = UPC_W'(4);
  localparam logic [UPC_W-1:0] L_OPER     = UPC_W'(5);
  localparam logic [UPC_W-1:0] L_OPOK     = UPC_W'(7);
  localparam logic [UPC_W-1:0] L_OPRED    = UPC_W'(8);
  localparam logic [UPC_W-1:0] L_OPWAIT   = UPC_W'(10);
  localparam logic [UPC_W-1:0] L_OPPUSH   = UPC_W'(12);
  localparam logic [UPC_W-1:0] L_LAST     = UPC_W'(13);
  localparam logic [UPC_W-1:0] L_FINRED   = UPC_W'(15);
  localparam logic [UPC_W-1:0] L_FINWAIT  = UPC_W'(17);
  localparam logic [UPC_W-1:0] L_EMITWAIT = UPC_W'(19);

  // Jump taken when cond holds, else fall through to the next step
  function automatic ucode_t ucode_rom(logic [UPC_W-1:0] addr);
    ucode_t w;
    w = '{uop: U_NOP, cond: C_ALWAYS, target: L_FETCH};
    case (addr)
      5'd0:  w = '{uop: U_FETCH,     cond: C_NO_BEAT,     target: L_FETCH};
      5'd1:  w = '{uop: U_NOP,       cond: C_DIGIT,       target: L_DIGIT};
      5'd2:  w = '{uop: U_NOP,       cond: C_OPER,        target: L_OPER};
      5'd3:  w = '{uop: U_BAD_OTHER, cond: C_ALWAYS,      target: L_LAST};
      5'd4:  w = '{uop: U_DIGIT,     cond: C_ALWAYS,      target: L_LAST};
      5'd5:  w = '{uop: U_NOP,       cond: C_IN_NUMBER,   target: L_OPOK};
      5'd6:  w = '{uop: U_MARK_BAD,  cond: C_ALWAYS,      target: L_LAST};
      5'd7:  w = '{uop: U_PUSH_NUM,  cond: C_NEVER,       target: L_FETCH};
      5'd8:  w = '{uop: U_NOP,       cond: C_NO_REDUCE,   target: L_OPPUSH};
      5'd9:  w = '{uop: U_ALU_START, cond: C_NEVER,       target: L_FETCH};
      5'd10: w = '{uop: U_NOP,       cond: C_ALU_BUSY,    target: L_OPWAIT};
      5'd11: w = '{uop: U_RED_WRITE, cond: C_ALWAYS,      target: L_OPRED};
      5'd12: w = '{uop: U_PUSH_OP,   cond: C_NEVER,       target: L_FETCH};
      5'd13: w = '{uop: U_NOP,       cond: C_NOT_LAST,    target: L_FETCH};
      5'd14: w = '{uop: U_FIN_PUSH,  cond: C_NEVER,       target: L_FETCH};
      5'd15: w = '{uop: U_NOP,       cond: C_NO_REDUCE,   target: L_EMITWAIT};
      5'd16: w = '{uop: U_ALU_START, cond: C_NEVER,       target: L_FETCH};
      5'd17: w = '{uop: U_NOP,       cond: C_ALU_BUSY,    target: L_FINWAIT};
      5'd18: w = '{uop: U_RED_WRITE, cond: C_ALWAYS,      target: L_FINRED};
      5'd19: w = '{uop: U_NOP,       cond: C_OUT_BLOCKED, target: L_EMITWAIT};
      5'd20: w = '{uop: U_EMIT,      cond: C_ALWAYS,      target: L_FETCH};
      default: w = '{uop: U_NOP,     cond: C_ALWAYS,      target: L_FETCH};
    endcase
    return w;
  endfunction

endpackage

@@ rtl/iee_char_if.sv @@
// Character input channel: valid/ready handshake with one character per beat.
// Depends on iee_pkg.
interface iee_char_if import iee_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              last_char;

  modport source (output valid, char_code, last_char, input ready);
  modport sink   (input valid, char_code, last_char, output ready);
endinterface

@@ rtl/iee_result_if.sv @@
// Result output channel: valid/ready handshake with one value and status per beat.
// Depends on iee_pkg.
interface iee_result_if import iee_pkg::*; ();
  logic   valid;
  logic   ready;
  value_t result_value;
  logic [1:0] status;

  modport source (output valid, result_value, status, input ready);
  modport sink   (input valid, result_value, status, output ready);
endinterface

@@ rtl/iee_alu.sv @@
// Fixed point arithmetic unit: registered add/sub, chunked multiply,
// bit-serial restoring divide, saturation. Depends on iee_pkg.
module iee_alu import iee_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  alu_state_t state, state_next;

  op_t                    op;
  logic                   neg;
  logic [VALUE_WIDTH-1:0] x;
  logic [MUL_PAD-1:0]     y;
  logic [PROD_W-1:0]      prod;
  logic [VALUE_WIDTH-1:0] dvsr;
  logic [VALUE_WIDTH-1:0] rem;
  logic [DIV_N-1:0]       quo;
  logic [CNT_W-1:0]       cnt;
  value_t                 value;
  logic                   ovf;
  logic                   dz;

  logic [VALUE_WIDTH-1:0] mag_a, mag_b;
  logic [VALUE_WIDTH:0]   sum;
  logic                   as_ovf;
  value_t                 as_value;

  logic [VALUE_WIDTH+MUL_CHUNK-1:0] partial;
  logic [PROD_W-1:0]                prod_next;

  logic [VALUE_WIDTH:0]   rem_sh, rem_diff;
  logic                   ge;
  logic [VALUE_WIDTH-1:0] rem_next;
  logic [DIV_N-1:0]       quo_next;

  logic [WIDE_W-1:0]      q, lim, qs;
  logic                   fin_ovf;
  logic [VALUE_WIDTH-1:0] fin_mag;
  value_t                 fin_value;

  function automatic logic [VALUE_WIDTH-1:0] mag(value_t v);
    return v[VALUE_WIDTH-1] ? (~v + VALUE_WIDTH'(1)) : v;
  endfunction

  assign mag_a = mag(req.a);
  assign mag_b = mag(req.b);

  // add / subtract with one guard bit
  always_comb begin
    if (req.op == OP_SUB) begin
      sum = {req.a[VALUE_WIDTH-1], req.a} - {req.b[VALUE_WIDTH-1], req.b};
    end else begin
      sum = {req.a[VALUE_WIDTH-1], req.a} + {req.b[VALUE_WIDTH-1], req.b};
    end
    as_ovf   = sum[VALUE_WIDTH] ^ sum[VALUE_WIDTH-1];
    as_value = as_ovf ? (sum[VALUE_WIDTH] ? VALUE_MIN : VALUE_MAX) : sum[VALUE_WIDTH-1:0];
  end

  // multiply: top chunk of y first
  assign partial   = x * y[MUL_PAD-1 -: MUL_CHUNK];
  assign prod_next = (prod << MUL_CHUNK) + PROD_W'(partial);

  // divide: one restoring step
  always_comb begin
    rem_sh   = {rem, quo[DIV_N-1]};
    rem_diff = rem_sh - {1'b0, dvsr};
    ge       = (rem_sh >= {1'b0, dvsr});
    rem_next = ge ? rem_diff[VALUE_WIDTH-1:0] : rem_sh[VALUE_WIDTH-1:0];
    quo_next = {quo[DIV_N-2:0], ge};
  end

  // saturate magnitude, apply sign
  always_comb begin
    q         = (op == OP_DIV) ? WIDE_W'(quo) : WIDE_W'(prod >> FRAC_BITS);
    lim       = neg ? LIM_NEG : LIM_POS;
    fin_ovf   = (q > lim);
    qs        = fin_ovf ? lim : q;
    fin_mag   = qs[VALUE_WIDTH-1:0];
    fin_value = neg ? (~fin_mag + VALUE_WIDTH'(1)) : fin_mag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= AS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      AS_IDLE: begin
        if (req.start && req.op == OP_MUL) begin
          state_next = AS_MUL;
        end else if (req.start && req.op == OP_DIV && mag_b != '0) begin
          state_next = AS_DIV;
        end
      end
      AS_MUL: if (cnt == CNT_W'(1)) state_next = AS_FIN;
      AS_DIV: if (cnt == CNT_W'(1)) state_next = AS_FIN;
      AS_FIN: state_next = AS_IDLE;
      default: state_next = AS_IDLE;
    endcase
    rsp.busy  = (state != AS_IDLE);
    rsp.value = value;
    rsp.ovf   = ovf;
    rsp.dz    = dz;
  end

  always_ff @(posedge clk) begin
    case (state)
      AS_IDLE: begin
        if (req.start) begin
          op   <= req.op;
          neg  <= req.a[VALUE_WIDTH-1] ^ req.b[VALUE_WIDTH-1];
          x    <= mag_a;
          y    <= MUL_PAD'(mag_b);
          prod <= '0;
          dvsr <= mag_b;
          rem  <= '0;
          quo  <= DIV_N'(mag_a) << FRAC_BITS;
          ovf  <= ((req.op == OP_ADD) || (req.op == OP_SUB)) && as_ovf;
          dz   <= (req.op == OP_DIV) && (mag_b == '0);
          case (req.op)
            OP_ADD, OP_SUB: value <= as_value;
            OP_MUL: cnt <= CNT_W'(MUL_STEPS);
            OP_DIV: begin
              cnt <= CNT_W'(DIV_N);
              if (mag_b == '0) value <= '0;
            end
            default: value <= '0;
          endcase
        end
      end
      AS_MUL: begin
        prod <= prod_next;
        y    <= y << MUL_CHUNK;
        cnt  <= cnt - CNT_W'(1);
      end
      AS_DIV: begin
        rem <= rem_next;
        quo <= quo_next;
        cnt <= cnt - CNT_W'(1);
      end
      AS_FIN: begin
        value <= fin_value;
        ovf   <= fin_ovf;
      end
      default: value <= value;
    endcase
  end

endmodule

@@ rtl/infix_expression_evaluator_unit.sv @@
// Infix expression evaluator top level: microcoded sequencer over value/operator stacks.
// Each beat is latched and decoded by the microcode; an operator or the last beat first reduces
// the stacks through the arithmetic unit (add/sub, chunked multiply or divide).
// The slowest reduction is the bit-serial divide, one quotient bit per cycle.
// One beat in work at a time; the result register lets the next beat in while a result waits.
// Reset (synchronous, rst high) clears counts, status, accumulator and the result valid.
module infix_expression_evaluator_unit import iee_pkg::*; (
  input logic        clk,
  input logic        rst,
  iee_char_if.sink   chars,
  iee_result_if.source results
);

  // Sequencer
  logic [UPC_W-1:0] step, step_next;
  ucode_t           uc;
  logic             take;

  // Latched beat
  logic [CHAR_W-1:0] ch;
  logic              last;

  // Number and stacks: s0/t0 are the stack tops
  logic [ACC_WIDTH-1:0] acc;
  logic                 in_number;
  value_t               s0, s1, s2;
  logic [1:0]           vc;
  op_t                  t0, t1;
  logic [1:0]           oc;
  status_t              status;
  logic [1:0]           new_prio;

  // Result register
  logic    out_valid;
  value_t  out_value;
  status_t out_status;

  // Arithmetic unit
  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  // Decoded character
  logic is_digit, is_op;
  op_t  ch_op;

  // Digit accumulate
  logic [ACC_WIDTH-1:0] acc_eff;
  logic [ACC_WIDTH+3:0] dig_sum;
  logic                 dig_sat;

  // Number push
  logic [PUSH_W-1:0] push_raw;
  logic [CMP_W-1:0]  push_cmp;
  logic              push_sat;
  value_t            push_value;

  logic    can_reduce;
  logic    final_ok;
  status_t final_status;

  iee_alu u_alu (
    .clk (clk),
    .rst (rst),
    .req (alu_req),
    .rsp (alu_rsp)
  );

  always_comb begin
    is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
    is_op    = (ch == CH_PLUS) || (ch == CH_MINUS) || (ch == CH_STAR) || (ch == CH_SLASH);
    case (ch)
      CH_PLUS:  ch_op = OP_ADD;
      CH_MINUS: ch_op = OP_SUB;
      CH_STAR:  ch_op = OP_MUL;
      default:  ch_op = OP_DIV;
    endcase
  end

  // acc*10 + digit as two shifts and two adds; saturates at all ones
  always_comb begin
    acc_eff = in_number ? acc : '0;
    dig_sum = ({4'b0, acc_eff} << 3) + ({4'b0, acc_eff} << 1)
            + (ACC_WIDTH+4)'(ch[3:0]);
    dig_sat = (dig_sum > (ACC_WIDTH+4)'(ACC_MAX));
  end

  always_comb begin
    push_raw   = PUSH_W'(acc) << FRAC_BITS;
    push_cmp   = CMP_W'(push_raw);
    push_sat   = (push_cmp > CMP_W'(VALUE_MAX));
    push_value = push_sat ? VALUE_MAX : push_cmp[VALUE_WIDTH-1:0];
  end

  // Reduce while the top operator binds at least as tightly as the pending one
  assign can_reduce = (vc == 2'd2 || vc == 2'd3) && (oc == 2'd1 || oc == 2'd2)
                      && (new_prio <= prio(t0));

  always_comb begin
    final_ok     = (vc == 2'd1) && (oc == 2'd0);
    final_status = final_ok ? status : raise_status(status, ST_MALFORMED);
  end

  assign uc   = ucode_rom(step);
  assign take = chars.valid && chars.ready;

  assign chars.ready = (uc.uop == U_FETCH) && !rst;

  assign alu_req.start = (uc.uop == U_ALU_START);
  assign alu_req.op    = t0;
  assign alu_req.a     = s1;
  assign alu_req.b     = s0;

  assign results.valid        = out_valid;
  assign results.result_value = out_value;
  assign results.status       = out_status;

  // Branch condition and next step
  always_comb begin
    logic hit;
    case (uc.cond)
      C_NEVER:       hit = 1'b0;
      C_ALWAYS:      hit = 1'b1;
      C_NO_BEAT:     hit = !chars.valid;
      C_DIGIT:       hit = is_digit;
      C_OPER:        hit = is_op;
      C_IN_NUMBER:   hit = in_number;
      C_NO_REDUCE:   hit = !can_reduce;
      C_ALU_BUSY:    hit = alu_rsp.busy;
      C_NOT_LAST:    hit = !last;
      C_OUT_BLOCKED: hit = out_valid && !results.ready;
      default:       hit = 1'b1;
    endcase
    step_next = hit ? uc.target : step + UPC_W'(1);
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= L_FETCH;
      acc       <= '0;
      in_number <= 1'b0;
      vc        <= 2'd0;
      oc        <= 2'd0;
      status    <= ST_OK;
      out_valid <= 1'b0;
    end else begin
      step <= step_next;
      if (uc.uop == U_EMIT) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
      case (uc.uop)
        U_DIGIT: begin
          acc       <= dig_sat ? ACC_MAX : dig_sum[ACC_WIDTH-1:0];
          in_number <= 1'b1;
          if (dig_sat) status <= raise_status(status, ST_OVERFLOW);
        end
        U_BAD_OTHER: begin
          if (ch != CH_SPACE) status <= raise_status(status, ST_MALFORMED);
        end
        U_MARK_BAD: status <= raise_status(status, ST_MALFORMED);
        U_PUSH_NUM: begin
          if (vc != 2'd3) vc <= vc + 2'd1;
          acc       <= '0;
          in_number <= 1'b0;
          if (push_sat) status <= raise_status(status, ST_OVERFLOW);
        end
        U_FIN_PUSH: begin
          if (in_number) begin
            if (vc != 2'd3) vc <= vc + 2'd1;
            acc       <= '0;
            in_number <= 1'b0;
            if (push_sat) status <= raise_status(status, ST_OVERFLOW);
          end else begin
            status <= raise_status(status, ST_MALFORMED);
          end
        end
        U_RED_WRITE: begin
          vc <= vc - 2'd1;
          oc <= oc - 2'd1;
          if (alu_rsp.dz) begin
            status <= raise_status(status, ST_DIV_ZERO);
          end else if (alu_rsp.ovf) begin
            status <= raise_status(status, ST_OVERFLOW);
          end
        end
        U_PUSH_OP: if (oc != 2'd2) oc <= oc + 2'd1;
        U_EMIT: begin
          acc       <= '0;
          in_number <= 1'b0;
          vc        <= 2'd0;
          oc        <= 2'd0;
          status    <= ST_OK;
        end
        default: ;
      endcase
    end
  end

  // Datapath payload
  always_ff @(posedge clk) begin
    if (take) begin
      ch   <= chars.char_code;
      last <= chars.last_char;
    end
    case (uc.uop)
      U_PUSH_NUM: begin
        new_prio <= prio(ch_op);
        if (vc != 2'd3) begin
          s0 <= push_value;
          s1 <= s0;
          s2 <= s1;
        end
      end
      U_FIN_PUSH: begin
        new_prio <= 2'd0;
        if (in_number && vc != 2'd3) begin
          s0 <= push_value;
          s1 <= s0;
          s2 <= s1;
        end
      end
      U_RED_WRITE: begin
        s0 <= alu_rsp.value;
        s1 <= s2;
        t0 <= t1;
      end
      U_PUSH_OP: begin
        if (oc != 2'd2) begin
          t0 <= ch_op;
          t1 <= t0;
        end
      end
      U_EMIT: begin
        out_status <= final_status;
        out_value  <= (final_status == ST_MALFORMED || final_status == ST_DIV_ZERO)
                      ? '0 : s0;
      end
      default: new_prio <= new_prio;
    endcase
  end

endmodule

@@ verif/tb_infix_expression_evaluator_unit.sv @@
// Self-checking testbench for the infix expression evaluator.
// Depends on iee_pkg, iee_char_if, iee_result_if and infix_expression_evaluator_unit.
// Streams expressions one character per beat and checks every result beat.
`timescale 1ns / 100ps

module tb_infix_expression_evaluator_unit;
  import iee_pkg::*;

  // Run sizing
  localparam int RANDOM_ITEMS = 1250;  // non-space characters in the random part
  localparam int STALL_LIMIT  = 4000;  // cycles without any beat before giving up
  localparam int DRAIN_CYCLES = 200;   // two chained divides plus emit, with margin

  // Magnitudes go up to 2^94 in a multiply, so keep twice the value width plus one.
  typedef logic [2*VALUE_WIDTH:0] wide_t;

  localparam wide_t MAG_MAX = (wide_t'(1) << (VALUE_WIDTH - 1)) - wide_t'(1);
  localparam logic signed [VALUE_WIDTH:0] SUM_HI = VALUE_MAX;
  localparam logic signed [VALUE_WIDTH:0] SUM_LO = VALUE_MIN;

  localparam logic [CHAR_W-1:0] OPERATOR_CHARS [4] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH};

  typedef struct {
    value_t  value;
    status_t status;
  } eval_result_t;

  // Receiver back-pressure styles
  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_LONG} rx_mode_t;

  // ---------------------------------------------------------------------------
  // Scoreboard: evaluates the expression alongside the block and holds the
  // results still owed by it.
  // ---------------------------------------------------------------------------
  class eval_scoreboard;
    eval_result_t pending_results[$];
    int           mismatches;

    logic [ACC_WIDTH-1:0] digits;
    bit                   in_number;
    value_t               val_stack[3];
    int                   val_count;
    op_t                  op_stack[2];
    int                   op_count;
    status_t              sticky;

    function new();
      mismatches = 0;
      clear();
    endfunction

    function void clear();
      digits    = '0;
      in_number = 1'b0;
      val_stack = '{default: '0};
      val_count = 0;
      op_stack  = '{default: OP_ADD};
      op_count  = 0;
      sticky    = ST_OK;
    endfunction

    // malformed / div-by-zero win over ok and overflow; overflow only over ok
    function void escalate(status_t s);
      if (s == ST_OVERFLOW) begin
        if (sticky == ST_OK) sticky = ST_OVERFLOW;
      end else if (sticky == ST_OK || sticky == ST_OVERFLOW) begin
        sticky = s;
      end
    endfunction

    function int unsigned binding(op_t op);
      return (op == OP_MUL || op == OP_DIV) ? 2 : 1;
    endfunction

    function wide_t magnitude_of(value_t v);
      logic signed [VALUE_WIDTH:0] e;
      e = v;
      if (e < 0) e = -e;
      return wide_t'($unsigned(e));
    endfunction

    // Signed result from sign and magnitude, saturating at the value limits
    function value_t signed_limit(bit neg, wide_t q);
      wide_t lim;
      lim = neg ? MAG_MAX + wide_t'(1) : MAG_MAX;
      if (q > lim) begin
        q = lim;
        escalate(ST_OVERFLOW);
      end
      return neg ? value_t'(-q) : value_t'(q);
    endfunction

    function value_t add_or_sub(value_t a, value_t b, bit sub);
      logic signed [VALUE_WIDTH:0] s;
      s = sub ? a - b : a + b;
      if (s > SUM_HI) begin
        escalate(ST_OVERFLOW);
        return VALUE_MAX;
      end
      if (s < SUM_LO) begin
        escalate(ST_OVERFLOW);
        return VALUE_MIN;
      end
      return value_t'(s);
    endfunction

    function value_t combine(value_t a, op_t op, value_t b);
      wide_t d;
      bit    neg;
      neg = a[VALUE_WIDTH-1] ^ b[VALUE_WIDTH-1];
      case (op)
        OP_ADD: return add_or_sub(a, b, 1'b0);
        OP_SUB: return add_or_sub(a, b, 1'b1);
        OP_MUL: return signed_limit(neg, (magnitude_of(a) * magnitude_of(b)) >> FRAC_BITS);
        default: begin
          d = magnitude_of(b);
          if (d == '0) begin
            escalate(ST_DIV_ZERO);
            return '0;
          end
          return signed_limit(neg, (magnitude_of(a) << FRAC_BITS) / d);
        end
      endcase
    endfunction

    // Fold the stacks while the top operator binds at least as tightly as need
    function void collapse(int unsigned need);
      value_t a, b;
      op_t    op;
      while (val_count >= 2 && op_count >= 1 && need <= binding(op_stack[op_count-1])) begin
        b  = val_stack[val_count-1];
        a  = val_stack[val_count-2];
        op = op_stack[op_count-1];
        op_count--;
        val_count -= 2;
        val_stack[val_count] = combine(a, op, b);
        val_count++;
      end
    endfunction

    function void push_number();
      wide_t v;
      v = wide_t'(digits) << FRAC_BITS;
      if (v > MAG_MAX) begin
        v = MAG_MAX;
        escalate(ST_OVERFLOW);
      end
      if (val_count < 3) begin
        val_stack[val_count] = value_t'(v);
        val_count++;
      end
      in_number = 1'b0;
      digits    = '0;
    endfunction

    function void note_char(logic [CHAR_W-1:0] c, logic last);
      logic [ACC_WIDTH+3:0] next_acc;
      op_t                  op;
      bit                   is_op;
      value_t               v;
      eval_result_t         r;
      is_op = 1'b0;
      op    = OP_ADD;
      if (c >= CH_ZERO && c <= CH_NINE) begin
        next_acc = (in_number ? (ACC_WIDTH+4)'(digits) : '0) * 10 + (ACC_WIDTH+4)'(c - CH_ZERO);
        if (next_acc > ACC_MAX) begin
          next_acc = ACC_MAX;
          escalate(ST_OVERFLOW);
        end
        digits    = next_acc[ACC_WIDTH-1:0];
        in_number = 1'b1;
      end else begin
        case (c)
          CH_PLUS: begin
            op = OP_ADD;
            is_op = 1'b1;
          end
          CH_MINUS: begin
            op = OP_SUB;
            is_op = 1'b1;
          end
          CH_STAR: begin
            op = OP_MUL;
            is_op = 1'b1;
          end
          CH_SLASH: begin
            op = OP_DIV;
            is_op = 1'b1;
          end
          CH_SPACE: ;
          default: escalate(ST_MALFORMED);
        endcase
      end

      if (is_op) begin
        if (!in_number) begin
          escalate(ST_MALFORMED);
        end else begin
          push_number();
          collapse(binding(op));
          if (op_count < 2) begin
            op_stack[op_count] = op;
            op_count++;
          end
        end
      end

      if (last) begin
        v = '0;
        if (in_number) push_number();
        else escalate(ST_MALFORMED);
        collapse(0);
        if (val_count == 1 && op_count == 0) v = val_stack[0];
        else escalate(ST_MALFORMED);
        if (sticky == ST_MALFORMED || sticky == ST_DIV_ZERO) v = '0;
        r.value  = v;
        r.status = sticky;
        pending_results = {pending_results, r};
        clear();
      end
    endfunction

    task report_mismatch(string what);
      mismatches++;
      $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    task check_result(value_t got_value, logic [1:0] got_status);
      eval_result_t want;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with none pending (value %0d, status %0d)",
                                  got_value, got_status));
        return;
      end
      want = pending_results.pop_front();
      if (got_value !== want.value)
        report_mismatch($sformatf("result_value %0d, want %0d", got_value, want.value));
      if (got_status !== want.status)
        report_mismatch($sformatf("status %0d, want %0d", got_status, want.status));
    endtask
  endclass

  // ---------------------------------------------------------------------------
  // Clock, reset, channels, DUT
  // ---------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  iee_char_if   chars();
  iee_result_if results();

  infix_expression_evaluator_unit DUT (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars),
    .results (results)
  );

  eval_scoreboard sb;

  logic [CHAR_W-1:0] expr_chars[$];  // expression being built for the next send
  int burst_left = 0;                // beats left in the current sender burst
  int chars_sent = 0;                // non-space beats accepted
  int quiet_cycles = 0;

  // ---------------------------------------------------------------------------
  // Expression builders. Most random expressions are well formed, so the
  // stacks fill and fold through every precedence combination; the rest are
  // broken on purpose or plain byte noise.
  // ---------------------------------------------------------------------------
  function automatic logic [CHAR_W-1:0] pick_operator();
    return OPERATOR_CHARS[2'($urandom_range(0, 3))];
  endfunction

  task automatic append_char(logic [CHAR_W-1:0] c);
    expr_chars = {expr_chars, c};
  endtask

  task automatic append_number();
    int len, r;
    r = $urandom_range(0, 99);
    // a bare zero now and then so divides by zero actually happen
    if (r < 6) begin
      append_char(CH_ZERO);
      return;
    end
    // mostly short numbers; a few long runs, the longest of which overflow the accumulator
    len = (r < 75) ? $urandom_range(1, 3) : (r < 93) ? $urandom_range(4, 6)
                                                      : $urandom_range(7, 11);
    repeat (len) begin
      append_char(CH_ZERO + CHAR_W'($urandom_range(0, 9)));
      // spaces inside a digit run are skipped, the run stays one number
      if ($urandom_range(0, 29) == 0) append_char(CH_SPACE);
    end
  endtask

  task automatic append_operator();
    if ($urandom_range(0, 4) == 0) append_char(CH_SPACE);
    append_char(pick_operator());
    if ($urandom_range(0, 4) == 0) append_char(CH_SPACE);
  endtask

  task automatic compose_expression();
    int shape;
    expr_chars.delete();
    shape = $urandom_range(0, 99);
    if (shape < 10) begin
      // byte noise: any character code at all
      repeat ($urandom_range(1, 6)) append_char(CHAR_W'($urandom_range(0, 255)));
    end else begin
      append_number();
      repeat ($urandom_range(0, 4)) begin
        append_operator();
        append_number();
      end
      // break some of the well formed ones
      if (shape >= 85) begin
        case ($urandom_range(0, 4))
          0: expr_chars.push_front(pick_operator());             // leading operator
          1: append_char(pick_operator());                       // ends on an operator
          2: expr_chars.insert($urandom_range(0, expr_chars.size()), pick_operator());
          3: expr_chars.insert($urandom_range(0, expr_chars.size()),
                               CHAR_W'($urandom_range(0, 255)));
          default: begin                                         // no number at all
            expr_chars.delete();
            repeat ($urandom_range(1, 3)) append_char(CH_SPACE);
          end
        endcase
      end
      if ($urandom_range(0, 19) == 0) append_char(CH_SPACE);  // last beat a space
    end
  endtask

  task automatic load_text(string s);
    expr_chars.delete();
    for (int i = 0; i < s.len(); i++) append_char(s[i]);
  endtask

  // ---------------------------------------------------------------------------
  // Sender: bursts of random length with random gaps. valid is only dropped
  // when a gap follows, so it never toggles within a step.
  // ---------------------------------------------------------------------------
  task automatic send_char(logic [CHAR_W-1:0] c, logic last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 90) : $urandom_range(1, 6);
      chars.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      // some long bursts give stretches with no sender idling at all
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    chars.valid     <= 1'b1;
    chars.char_code <= c;
    chars.last_char <= last;
    @(posedge clk);
    while (!chars.ready) @(posedge clk);
    sb.note_char(c, last);
    if (c != CH_SPACE) chars_sent++;
  endtask

  task automatic send_expression();
    for (int i = 0; i < expr_chars.size(); i++) send_char(expr_chars[i], i == expr_chars.size() - 1);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: ready follows a style that changes after a random stretch:
  // always open, coin flip, sparse periodic, or long stalls with single
  // ready cycles between them.
  // ---------------------------------------------------------------------------
  rx_mode_t rx_mode = RX_OPEN;
  int       rx_phase = 0;
  int       rx_hold = 0;

  always @(posedge clk) begin
    if (rx_phase == 0) begin
      rx_mode  = rx_mode_t'($urandom_range(0, 3));
      rx_phase = $urandom_range(100, 400);
    end
    rx_phase--;
    case (rx_mode)
      RX_OPEN:   results.ready <= 1'b1;
      RX_COIN:   results.ready <= ($urandom_range(0, 1) == 1);
      RX_SPARSE: results.ready <= (rx_phase % 5 == 0);
      default: begin
        results.ready <= (rx_hold == 0);
        if (rx_hold == 0) rx_hold = $urandom_range(10, 120);
        else rx_hold--;
      end
    endcase
  end

  // Every accepted result beat is checked against the oldest pending one.
  always @(posedge clk) begin
    if (!rst && results.valid && results.ready) sb.check_result(results.result_value, results.status);
  end

  // Watchdog: any beat on either channel restarts the count.
  always @(posedge clk) begin
    if (rst || (chars.valid && chars.ready) || (results.valid && results.ready)) begin
      quiet_cycles = 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles++;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    sb = new();
    chars.valid     <= 1'b0;
    chars.char_code <= '0;
    chars.last_char <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: leading operator then divide by zero (malformed must stay)
    load_text("+7/0");
    send_expression();
    // all four operators with precedence, a negative fraction, last beat a space
    load_text("1+5*3/2-9 ");
    send_expression();
    // doubled operator and an expression ending on an operator
    load_text("6*/");
    send_expression();
    // digit run past 32 bits saturates the accumulator
    load_text("4294967296");
    send_expression();
    // a stray character with no number, all char bits set
    expr_chars.delete();
    append_char(8'hFF);
    send_expression();

    chars_sent = 0;
    while (chars_sent < RANDOM_ITEMS) begin
      compose_expression();
      send_expression();
    end
    chars.valid <= 1'b0;

    // Let the block finish; the watchdog covers a result that never shows.
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
